FILE: rtl/core/sit_pkg.sv
`timescale 1ns / 1ps
// Shared widths, data types and pipeline payload structs for the segment intersection test.
package sit_pkg;

    // Width of one input coordinate, two's complement.
    localparam int COORD_BITS = 16;
    // A coordinate difference needs one more bit.
    localparam int DIFF_W     = COORD_BITS + 1;
    // Product of two differences.
    localparam int PROD_W     = 2 * DIFF_W;
    // Difference of two products (a 2-D cross product).
    localparam int CROSS_W    = PROD_W + 1;
    // Number of coordinates in one input word.
    localparam int NUM_COORDS = 8;
    // Slave tdata width: all coordinates, padded to whole bytes.
    localparam int S_TDATA_W  = ((NUM_COORDS * COORD_BITS + 7) / 8) * 8;
    // Master tdata width: the single result bit, padded to a byte.
    localparam int M_TDATA_W  = 8;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_val_t;
    typedef logic signed [PROD_W-1:0]     prod_val_t;
    typedef logic signed [CROSS_W-1:0]    cross_val_t;

    // Stage 1 payload: direction vectors, start offset and bounding boxes.
    typedef struct packed {
        diff_val_t rx;
        diff_val_t ry;
        diff_val_t sx;
        diff_val_t sy;
        diff_val_t qx;
        diff_val_t qy;
        coord_t    lo1x;
        coord_t    hi1x;
        coord_t    lo2x;
        coord_t    hi2x;
        coord_t    lo1y;
        coord_t    hi1y;
        coord_t    lo2y;
        coord_t    hi2y;
    } diff_t;

    // Stage 2 payload: the six partial products and projection overlap flags.
    typedef struct packed {
        prod_val_t rx_sy;
        prod_val_t ry_sx;
        prod_val_t qx_sy;
        prod_val_t qy_sx;
        prod_val_t qx_ry;
        prod_val_t qy_rx;
        logic      x_meet;
        logic      y_meet;
    } prod_t;

    // Stage 3 payload: determinant, both numerators and the box overlap.
    typedef struct packed {
        cross_val_t den;
        cross_val_t tn;
        cross_val_t un;
        logic       box_meet;
    } cross_t;

endpackage

FILE: rtl/core/sit_diff_stage.sv
`timescale 1ns / 1ps
// First pipeline stage: coordinate differences and per-segment bounding boxes.
module sit_diff_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [sit_pkg::S_TDATA_W-1:0] in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sit_pkg::diff_t        out_data
);

    sit_pkg::coord_t ax, ay, bx, by, cx, cy, dx, dy;
    sit_pkg::diff_t  data_next;
    sit_pkg::diff_t  data_reg;
    logic            valid_reg;

    // Unpack the coordinates, first field in the lowest bits.
    always_comb begin
        ax = sit_pkg::coord_t'(in_data[0*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        ay = sit_pkg::coord_t'(in_data[1*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        bx = sit_pkg::coord_t'(in_data[2*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        by = sit_pkg::coord_t'(in_data[3*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        cx = sit_pkg::coord_t'(in_data[4*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        cy = sit_pkg::coord_t'(in_data[5*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        dx = sit_pkg::coord_t'(in_data[6*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
        dy = sit_pkg::coord_t'(in_data[7*sit_pkg::COORD_BITS +: sit_pkg::COORD_BITS]);
    end

    // Direction vectors r and s, offset q from first start to second start.
    always_comb begin
        data_next.rx = sit_pkg::diff_val_t'(bx) - sit_pkg::diff_val_t'(ax);
        data_next.ry = sit_pkg::diff_val_t'(by) - sit_pkg::diff_val_t'(ay);
        data_next.sx = sit_pkg::diff_val_t'(dx) - sit_pkg::diff_val_t'(cx);
        data_next.sy = sit_pkg::diff_val_t'(dy) - sit_pkg::diff_val_t'(cy);
        data_next.qx = sit_pkg::diff_val_t'(cx) - sit_pkg::diff_val_t'(ax);
        data_next.qy = sit_pkg::diff_val_t'(cy) - sit_pkg::diff_val_t'(ay);
        // Bounding boxes of both segments.
        data_next.lo1x = (ax < bx) ? ax : bx;
        data_next.hi1x = (ax < bx) ? bx : ax;
        data_next.lo2x = (cx < dx) ? cx : dx;
        data_next.hi2x = (cx < dx) ? dx : cx;
        data_next.lo1y = (ay < by) ? ay : by;
        data_next.hi1y = (ay < by) ? by : ay;
        data_next.lo2y = (cy < dy) ? cy : dy;
        data_next.hi2y = (cy < dy) ? dy : cy;
    end

    // The stage takes a word when it is empty or its content moves on.
    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/sit_mult_stage.sv
`timescale 1ns / 1ps
// Second pipeline stage: the six partial products and projection overlap tests.
module sit_mult_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sit_pkg::diff_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sit_pkg::prod_t  out_data
);

    sit_pkg::prod_t data_next;
    sit_pkg::prod_t data_reg;
    logic           valid_reg;

    // Products for cross(r,s), cross(q,s) and cross(q,r).
    always_comb begin
        data_next.rx_sy = sit_pkg::prod_val_t'(in_data.rx) * sit_pkg::prod_val_t'(in_data.sy);
        data_next.ry_sx = sit_pkg::prod_val_t'(in_data.ry) * sit_pkg::prod_val_t'(in_data.sx);
        data_next.qx_sy = sit_pkg::prod_val_t'(in_data.qx) * sit_pkg::prod_val_t'(in_data.sy);
        data_next.qy_sx = sit_pkg::prod_val_t'(in_data.qy) * sit_pkg::prod_val_t'(in_data.sx);
        data_next.qx_ry = sit_pkg::prod_val_t'(in_data.qx) * sit_pkg::prod_val_t'(in_data.ry);
        data_next.qy_rx = sit_pkg::prod_val_t'(in_data.qy) * sit_pkg::prod_val_t'(in_data.rx);
        // Closed intervals overlap when each one starts before the other ends.
        data_next.x_meet = (in_data.lo1x <= in_data.hi2x) && (in_data.lo2x <= in_data.hi1x);
        data_next.y_meet = (in_data.lo1y <= in_data.hi2y) && (in_data.lo2y <= in_data.hi1y);
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/sit_cross_stage.sv
`timescale 1ns / 1ps
// Third pipeline stage: determinant and the two crossing-point numerators.
module sit_cross_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sit_pkg::prod_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output sit_pkg::cross_t out_data
);

    sit_pkg::cross_t data_next;
    sit_pkg::cross_t data_reg;
    logic            valid_reg;

    // den = cross(r,s), tn = cross(q,s), un = cross(q,r).
    always_comb begin
        data_next.den = sit_pkg::cross_val_t'(in_data.rx_sy)
                      - sit_pkg::cross_val_t'(in_data.ry_sx);
        data_next.tn  = sit_pkg::cross_val_t'(in_data.qx_sy)
                      - sit_pkg::cross_val_t'(in_data.qy_sx);
        data_next.un  = sit_pkg::cross_val_t'(in_data.qx_ry)
                      - sit_pkg::cross_val_t'(in_data.qy_rx);
        data_next.box_meet = in_data.x_meet & in_data.y_meet;
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: rtl/core/sit_decide_stage.sv
`timescale 1ns / 1ps
// Last pipeline stage: sign-aware range checks and the registered result word.
module sit_decide_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  sit_pkg::cross_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_touch
);

    logic den_zero;
    logic den_neg;
    logic t_ok;
    logic u_ok;
    logic touch_next;
    logic touch_reg;
    logic valid_reg;

    // Parameters t = tn/den and u = un/den must lie in [0, 1]. Rather than
    // dividing, compare against den with the bounds swapped when den < 0.
    // With den equal to zero the segments are parallel; they are collinear
    // exactly when both numerators vanish too.
    always_comb begin
        den_zero = (in_data.den == '0);
        den_neg  = in_data.den[sit_pkg::CROSS_W-1];
        if (den_neg) begin
            t_ok = (in_data.tn <= sit_pkg::cross_val_t'(0)) && (in_data.tn >= in_data.den);
            u_ok = (in_data.un <= sit_pkg::cross_val_t'(0)) && (in_data.un >= in_data.den);
        end else begin
            t_ok = (in_data.tn >= sit_pkg::cross_val_t'(0)) && (in_data.tn <= in_data.den);
            u_ok = (in_data.un >= sit_pkg::cross_val_t'(0)) && (in_data.un <= in_data.den);
        end
        if (den_zero) begin
            touch_next = (in_data.tn == '0) && (in_data.un == '0) && in_data.box_meet;
        end else begin
            touch_next = t_ok && u_ok;
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            touch_reg <= touch_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_touch = touch_reg;

endmodule

FILE: rtl/core/segment_intersection_test.sv
`timescale 1ns / 1ps
// Top level of the segment intersection test: four-stage pipeline and stream ports.
//
// Usage: one slave word carries two 2-D segments as eight signed coordinates
// (first start x/y, first end x/y, second start x/y, second end x/y). For each
// accepted word exactly one master word follows, in order, whose bit 0 is 1 when
// the two closed segments share at least one point.
// Pipeline: an accepted word passes through four registered stages in order
// (differences, products, cross products, decision) before m_tvalid shows it.
// Throughput: one word per cycle unless m_tready stalls. Each stage holds one word
// and moves it on when the next stage is empty or moving, so empty stages are
// filled during a stall and s_tready only falls once all four stages hold words.
// Reset: aresetn low clears all stage valid bits; no result is pending after it.
// Stall: while m_tready is low, m_tvalid and m_tdata hold their values.
module segment_intersection_test (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // From bit 0 up: first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y.
    input  logic [sit_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // From bit 0 up: segments_touch, then zero padding.
    output logic [sit_pkg::M_TDATA_W-1:0] m_tdata
);

    sit_pkg::diff_t  diff_data;
    sit_pkg::prod_t  prod_data;
    sit_pkg::cross_t cross_data;
    logic            diff_valid, diff_ready;
    logic            prod_valid, prod_ready;
    logic            cross_valid, cross_ready;
    logic            touch;

    sit_diff_stage u_diff (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .out_data  (diff_data)
    );

    sit_mult_stage u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .in_data   (diff_data),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    sit_cross_stage u_cross (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (cross_valid),
        .out_ready (cross_ready),
        .out_data  (cross_data)
    );

    sit_decide_stage u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cross_valid),
        .in_ready  (cross_ready),
        .in_data   (cross_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_touch (touch)
    );

    // Result bit in the lowest position, padding bits held at zero.
    assign m_tdata = {{(sit_pkg::M_TDATA_W-1){1'b0}}, touch};

endmodule

FILE: rtl/core/sit_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the segment intersection test, bound to the top level.
module sit_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [sit_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [sit_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result word stays offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    // A stalled result word keeps its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // Back-pressure reaches the input only when the output is stalled.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    // A waiting input word stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while waiting");

endmodule

bind segment_intersection_test sit_checker u_sit_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: sim/tb_segment_intersection_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the segment intersection test: stream driver, predictor and scoreboard.
module tb_segment_intersection_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_PAIRS    = 167;

    // Fields of one input word, the first segment's start x in the lowest bits.
    typedef struct packed {
        sit_pkg::coord_t second_end_y;
        sit_pkg::coord_t second_end_x;
        sit_pkg::coord_t second_start_y;
        sit_pkg::coord_t second_start_x;
        sit_pkg::coord_t first_end_y;
        sit_pkg::coord_t first_end_x;
        sit_pkg::coord_t first_start_y;
        sit_pkg::coord_t first_start_x;
    } seg_pair_t;

    // Holds the expected touch flags in order and compares each result word.
    class touch_scoreboard;
        bit touch_q[$];
        int errors;

        function longint cross_prod(longint ux, longint uy, longint vx, longint vy);
            return ux * vy - uy * vx;
        endfunction

        function bit spans_overlap(longint a, longint b, longint c, longint d);
            longint lo1, hi1, lo2, hi2;
            lo1 = (a < b) ? a : b;
            hi1 = (a < b) ? b : a;
            lo2 = (c < d) ? c : d;
            hi2 = (c < d) ? d : c;
            return ((lo1 > lo2) ? lo1 : lo2) <= ((hi1 < hi2) ? hi1 : hi2);
        endfunction

        // Exact test: cross-multiply by the sign of the determinant instead of dividing.
        function bit segments_meet(seg_pair_t p);
            longint ax, ay, bx, by, cx, cy, dx, dy;
            longint rx, ry, sx, sy, qx, qy, den, tn, un;
            bit on_line;
            ax = p.first_start_x;
            ay = p.first_start_y;
            bx = p.first_end_x;
            by = p.first_end_y;
            cx = p.second_start_x;
            cy = p.second_start_y;
            dx = p.second_end_x;
            dy = p.second_end_y;
            rx = bx - ax;
            ry = by - ay;
            sx = dx - cx;
            sy = dy - cy;
            qx = cx - ax;
            qy = cy - ay;
            den = cross_prod(rx, ry, sx, sy);
            if (den != 0) begin
                tn = cross_prod(qx, qy, sx, sy);
                un = cross_prod(qx, qy, rx, ry);
                if (den < 0) begin
                    den = -den;
                    tn = -tn;
                    un = -un;
                end
                return tn >= 0 && tn <= den && un >= 0 && un <= den;
            end
            // Parallel lines: touch only when all four points share one line.
            on_line = cross_prod(rx, ry, qx, qy) == 0 &&
                      cross_prod(rx, ry, dx - ax, dy - ay) == 0 &&
                      cross_prod(sx, sy, ax - cx, ay - cy) == 0 &&
                      cross_prod(sx, sy, bx - cx, by - cy) == 0;
            return on_line && spans_overlap(ax, bx, cx, dx) && spans_overlap(ay, by, cy, dy);
        endfunction

        function void note_pair(seg_pair_t p);
            touch_q.push_back(segments_meet(p));
        endfunction

        function void check_word(logic [sit_pkg::M_TDATA_W-1:0] word);
            bit want;
            if (touch_q.size() == 0) begin
                $error("segments_touch: no word expected, actual %0d", word[0]);
                errors++;
                return;
            end
            want = touch_q.pop_front();
            if (word[0] !== want) begin
                $error("segments_touch: expected %0d, actual %0d", want, word[0]);
                errors++;
            end
        endfunction

        function int pending();
            return touch_q.size();
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sit_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sit_pkg::M_TDATA_W-1:0] m_tdata;

    touch_scoreboard sb = new();
    int send_idle;
    int recv_idle;
    int stall_cycles;

    segment_intersection_test uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Receiver stalls at random, redrawn at every falling edge.
    initial m_tready = 1'b0;
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Result monitor and watchdog on cycles with no word moving.
    initial stall_cycles = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_word(m_tdata);
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    function automatic seg_pair_t mk_pair(int ax, int ay, int bx, int by,
                                          int cx, int cy, int dx, int dy);
        seg_pair_t p;
        p.first_start_x  = sit_pkg::coord_t'(ax);
        p.first_start_y  = sit_pkg::coord_t'(ay);
        p.first_end_x    = sit_pkg::coord_t'(bx);
        p.first_end_y    = sit_pkg::coord_t'(by);
        p.second_start_x = sit_pkg::coord_t'(cx);
        p.second_start_y = sit_pkg::coord_t'(cy);
        p.second_end_x   = sit_pkg::coord_t'(dx);
        p.second_end_y   = sit_pkg::coord_t'(dy);
        return p;
    endfunction

    function automatic int rnd(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic int extreme_val();
        case ($urandom_range(6))
            0: return -32768;
            1: return -32767;
            2: return -1;
            3: return 0;
            4: return 1;
            5: return 32766;
            default: return 32767;
        endcase
    endfunction

    // Mix of raw noise, dense small grids, constructed collinear, crossing and
    // parallel pairs and coordinate extremes, so that every decision path is hit often.
    function automatic seg_pair_t random_pair();
        int kind, bx, by, ux, uy, ex, ey, n, m, t1, t2, t3, t4, px, py;
        kind = $urandom_range(99);
        bx = rnd(16000);
        by = rnd(16000);
        ux = rnd(64);
        uy = rnd(64);
        t1 = rnd(8);
        t2 = rnd(8);
        t3 = rnd(8);
        t4 = rnd(8);
        n  = $urandom_range(1, 8);
        m  = $urandom_range(n);
        if (kind < 20) begin
            return seg_pair_t'({$urandom, $urandom, $urandom, $urandom});
        end else if (kind < 45) begin
            return mk_pair(rnd(4), rnd(4), rnd(4), rnd(4), rnd(4), rnd(4), rnd(4), rnd(4));
        end else if (kind < 65) begin
            return mk_pair(bx + t1 * ux, by + t1 * uy, bx + t2 * ux, by + t2 * uy,
                           bx + t3 * ux, by + t3 * uy, bx + t4 * ux, by + t4 * uy);
        end else if (kind < 80) begin
            // Second segment runs through a point of the first, possibly ending there.
            px = bx + m * ux;
            py = by + m * uy;
            ex = rnd(1000);
            ey = rnd(1000);
            t1 = $urandom_range(3);
            t2 = $urandom_range(3);
            return mk_pair(bx, by, bx + n * ux, by + n * uy,
                           px + t1 * ex, py + t1 * ey, px - t2 * ex, py - t2 * ey);
        end else if (kind < 90) begin
            ex = rnd(3);
            ey = rnd(3);
            return mk_pair(bx, by, bx + n * ux, by + n * uy,
                           bx + ex + t3 * ux, by + ey + t3 * uy,
                           bx + ex + t4 * ux, by + ey + t4 * uy);
        end
        return mk_pair(extreme_val(), extreme_val(), extreme_val(), extreme_val(),
                       extreme_val(), extreme_val(), extreme_val(), extreme_val());
    endfunction

    // Offer one word after a random gap and hold it until accepted; entered at a falling edge.
    task automatic send_pair(input seg_pair_t p);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_pair(p);
        @(negedge aclk);
    endtask

    task automatic send_directed();
        // Proper crossing, end point touch, T junction and near miss.
        send_pair(mk_pair(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(mk_pair(0, 0, 10, 0, 10, 0, 10, 10));
        send_pair(mk_pair(0, 0, 10, 0, 5, 0, 5, 10));
        send_pair(mk_pair(0, 0, 10, 0, 5, 1, 5, 10));
        send_pair(mk_pair(0, 0, 1, 1, 3, 0, 4, -1));
        // Parallel distinct lines.
        send_pair(mk_pair(0, 0, 10, 0, 0, 1, 10, 1));
        // Collinear: overlap, end to end, gap, containment, vertical overlap.
        send_pair(mk_pair(0, 0, 10, 0, 5, 0, 15, 0));
        send_pair(mk_pair(0, 0, 10, 10, 10, 10, 20, 20));
        send_pair(mk_pair(0, 0, 10, 10, 11, 11, 20, 20));
        send_pair(mk_pair(-5, -5, 5, 5, 3, 3, -3, -3));
        send_pair(mk_pair(3, -10, 3, 10, 3, 5, 3, 20));
        // Point segments: on the other segment, off its line, on its line
        // but outside, two equal points, two distinct points.
        send_pair(mk_pair(2, 2, 2, 2, 0, 0, 4, 4));
        send_pair(mk_pair(2, 3, 2, 3, 0, 0, 4, 4));
        send_pair(mk_pair(5, 5, 5, 5, 0, 0, 4, 4));
        send_pair(mk_pair(7, -7, 7, -7, 7, -7, 7, -7));
        send_pair(mk_pair(7, -7, 7, -7, 7, -6, 7, -6));
        // Extremes of the coordinate range.
        send_pair(mk_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(mk_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
        send_pair(mk_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(mk_pair(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
        send_pair(mk_pair(-32768, 0, 0, 0, 0, 0, 32767, 0));
        send_pair(mk_pair(-1, 0, 0, -1, -1, -1, 0, 0));
        send_pair(mk_pair(32767, -32768, -32768, 32767, 32767, 32767, 32766, 32766));
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        send_idle = 31;
        recv_idle = 54;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_directed();
        for (int i = 0; i < PHASE_PAIRS; i++) send_pair(random_pair());

        send_idle = 54;
        recv_idle = 31;
        for (int i = 0; i < PHASE_PAIRS; i++) send_pair(random_pair());

        send_idle = 0;
        recv_idle = 0;
        for (int i = 0; i < PHASE_PAIRS; i++) send_pair(random_pair());
        s_tvalid <= 1'b0;

        // Drain the pipeline, then keep watching the output for any stray word.
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/sit_pkg.sv
rtl/core/sit_diff_stage.sv
rtl/core/sit_mult_stage.sv
rtl/core/sit_cross_stage.sv
rtl/core/sit_decide_stage.sv
rtl/core/segment_intersection_test.sv
rtl/core/sit_checker.sv
sim/tb_segment_intersection_test.sv
